>>> rtl/dpr_pkg.sv
// Shared constants and controller/datapath handshake types for demand page replacement.
`timescale 1ns / 1ps
package dpr_pkg;

  localparam int MAX_PAGES_DEF = 64;
  localparam int FRAMES_DEF    = 32;
  localparam int AGE_BITS_DEF  = 16;

  // wide enough to compare page numbers against any page count in range
  localparam int CMP_W = 11;

  localparam logic [1:0] CMD_FAULT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_PAGES  = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_AGE  = 1'b1;

  typedef struct packed {
    logic accept;
    logic decode;
    logic alloc;
    logic q_pop;
    logic q_take;
    logic sweep_start;
    logic sweep_step;
    logic rd_victim;
    logic evict;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic no_result;
    logic bad;
    logic fault;
    logic vpn_valid;
    logic free;
    logic policy;
    logic q_empty;
    logic q_hit;
    logic sweep_done;
    logic found;
  } sts_t;

endpackage

>>> rtl/dpr_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module dpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dpr_ctrl.sv
// Sequencing state machine for fault handling, queue pops and page table sweeps.
`timescale 1ns / 1ps
module dpr_ctrl import dpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic res_valid_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOOK   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_QPOP   = 4'd3;
  localparam logic [3:0] S_QCHK   = 4'd4;
  localparam logic [3:0] S_SWEEP  = 4'd5;
  localparam logic [3:0] S_VRD    = 4'd6;
  localparam logic [3:0] S_VGET   = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_DEC;
      end
      S_DEC: begin
        ctl_o.decode = 1'b1;
        if (sts_i.no_result) begin
          state_d = S_IDLE;
        end else if (sts_i.bad || (sts_i.vpn_valid == sts_i.fault && !sts_i.vpn_valid)) begin
          state_d = S_OUT;
        end else if (sts_i.fault && sts_i.vpn_valid) begin
          state_d = S_OUT;
        end else if (sts_i.fault && sts_i.free) begin
          ctl_o.alloc = 1'b1;
          state_d = S_COMMIT;
        end else if (sts_i.fault && sts_i.policy == POLICY_FIFO) begin
          state_d = S_QPOP;
        end else if (sts_i.fault || sts_i.vpn_valid) begin
          ctl_o.sweep_start = 1'b1;
          state_d = S_SWEEP;
        end else begin
          state_d = S_OUT;
        end
      end
      S_QPOP: begin
        if (sts_i.q_empty) begin
          ctl_o.sweep_start = 1'b1;
          state_d = S_SWEEP;
        end else begin
          ctl_o.q_pop = 1'b1;
          state_d = S_QCHK;
        end
      end
      S_QCHK: begin
        if (sts_i.q_hit) begin
          ctl_o.q_take = 1'b1;
          state_d = S_VRD;
        end else begin
          state_d = S_QPOP;
        end
      end
      S_SWEEP: begin
        ctl_o.sweep_step = 1'b1;
        if (sts_i.sweep_done) begin
          if (!sts_i.fault) begin
            state_d = S_OUT;
          end else if (sts_i.found) begin
            state_d = S_VRD;
          end else begin
            state_d = S_COMMIT;
          end
        end
      end
      S_VRD: begin
        ctl_o.rd_victim = 1'b1;
        state_d = S_VGET;
      end
      S_VGET: begin
        ctl_o.evict = 1'b1;
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_OUT);

endmodule

>>> rtl/dpr_datapath.sv
// Page table state, replacement queue, age store, counters and result registers.
`timescale 1ns / 1ps
module dpr_datapath import dpr_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  parameter int FRAMES    = FRAMES_DEF,
  parameter int AGE_BITS  = AGE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  vpn_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  output logic [4:0]  frame_o,
  output logic        evicted_o,
  output logic [5:0]  victim_page_o,
  output logic        write_back_o,
  output logic        not_resident_o,
  output logic [31:0] disk_reads_o,
  output logic [31:0] disk_writes_o
);

  localparam int PW = $clog2(MAX_PAGES);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int IW = $clog2(MAX_PAGES + 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  logic             policy_q;
  logic [6:0]       pages_q;
  logic [1:0]       cmd_q;
  logic [5:0]       vpn_q;
  logic [MAX_PAGES-1:0] valid_q, dirty_q, agew_q;
  logic [CW-1:0]    handed_q;
  logic [FW-1:0]    head_q;
  logic [CW-1:0]    cnt_q;
  logic [31:0]      reads_q, writes_q;
  logic [FW-1:0]    frame_q;
  logic             ev_q, wb_q, nr_q;
  logic [PW-1:0]    victim_q;
  logic             found_q;
  logic [AGE_BITS-1:0] best_q;
  logic [IW-1:0]    idx_q;
  logic             pv_q;
  logic [PW-1:0]    pidx_q;

  logic [PW-1:0]    vidx;
  logic [CMP_W-1:0] lim;
  logic             bad, fault;
  logic [FW-1:0]    frame_rd;
  logic [PW-1:0]    fifo_rd;
  logic [AGE_BITS-1:0] age_rd, age_cur;
  logic [FW-1:0]    head_inc;
  logic             q_full;
  logic [FW-1:0]    push_head;
  logic [CW-1:0]    push_cnt;
  logic [31:0]      push_sum;
  logic [FW-1:0]    push_addr;
  logic             age_we;
  logic [PW-1:0]    age_waddr;
  logic [AGE_BITS-1:0] age_wdata;
  logic             q_hit;

  assign vidx  = PW'(vpn_q);
  assign lim   = (32'(pages_q) > MAX_PAGES) ? CMP_W'(MAX_PAGES) : CMP_W'(pages_q);
  assign bad   = (CMP_W'(vpn_q) >= lim);
  assign fault = (cmd_q == CMD_FAULT);

  assign head_inc  = (32'(head_q) == FRAMES - 1) ? '0 : head_q + 1'b1;
  assign q_full    = (32'(cnt_q) >= FRAMES);
  assign push_head = q_full ? head_inc : head_q;
  assign push_cnt  = q_full ? CW'(FRAMES - 1) : cnt_q;
  assign push_sum  = (32'(push_head) + 32'(push_cnt) >= FRAMES) ?
                     32'(push_head) + 32'(push_cnt) - 32'(FRAMES) :
                     32'(push_head) + 32'(push_cnt);
  assign push_addr = FW'(push_sum);

  assign q_hit   = (32'(fifo_rd) < MAX_PAGES) && valid_q[fifo_rd];
  assign age_cur = agew_q[pidx_q] ? age_rd : '0;

  always_comb begin
    age_we    = 1'b0;
    age_waddr = pidx_q;
    age_wdata = '0;
    if (ctl_i.evict && policy_q == POLICY_AGE) begin
      age_we    = 1'b1;
      age_waddr = victim_q;
    end else if (ctl_i.sweep_step && pv_q && !fault) begin
      if (pidx_q == vidx) begin
        age_we = 1'b1;
      end else if (valid_q[pidx_q] && age_cur != AGE_MAX) begin
        age_we    = 1'b1;
        age_wdata = age_cur + 1'b1;
      end
    end
  end

  dpr_ram #(.WIDTH(FW), .DEPTH(MAX_PAGES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.commit),
    .waddr_i (vidx),
    .wdata_i (frame_q),
    .raddr_i (ctl_i.rd_victim ? victim_q : vidx),
    .rdata_o (frame_rd)
  );

  dpr_ram #(.WIDTH(PW), .DEPTH(FRAMES)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.commit && policy_q == POLICY_FIFO),
    .waddr_i (push_addr),
    .wdata_i (vidx),
    .raddr_i (head_q),
    .rdata_o (fifo_rd)
  );

  dpr_ram #(.WIDTH(AGE_BITS), .DEPTH(MAX_PAGES)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (age_waddr),
    .wdata_i (age_wdata),
    .raddr_i (PW'(idx_q)),
    .rdata_o (age_rd)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q <= cmd_i;
      vpn_q <= vpn_i;
    end
    if (ctl_i.decode) begin
      frame_q <= ctl_i.alloc ? FW'(handed_q) :
                 ((!bad && valid_q[vidx]) ? frame_rd : '0);
      nr_q    <= bad || (!fault && !valid_q[vidx]);
      ev_q    <= 1'b0;
      wb_q    <= 1'b0;
    end
    if (ctl_i.q_take) begin
      victim_q <= fifo_rd;
    end
    if (ctl_i.sweep_start) begin
      idx_q <= '0;
    end else if (ctl_i.sweep_step && 32'(idx_q) < MAX_PAGES) begin
      idx_q  <= idx_q + 1'b1;
      pidx_q <= PW'(idx_q);
    end
    if (ctl_i.sweep_step && pv_q && fault && valid_q[pidx_q] &&
        (!found_q || age_cur >= best_q)) begin
      victim_q <= pidx_q;
      best_q   <= age_cur;
    end
    if (ctl_i.evict) begin
      frame_q <= frame_rd;
      ev_q    <= 1'b1;
      wb_q    <= dirty_q[victim_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_FIFO;
      pages_q  <= 7'd64;
      valid_q  <= '0;
      dirty_q  <= '0;
      agew_q   <= '0;
      handed_q <= '0;
      head_q   <= '0;
      cnt_q    <= '0;
      reads_q  <= '0;
      writes_q <= '0;
      found_q  <= 1'b0;
      pv_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_POLICY) begin
          policy_q <= cfg_data_i[0];
        end else begin
          pages_q <= cfg_data_i;
        end
      end
      if (ctl_i.decode && cmd_q == CMD_WRITE && !bad && valid_q[vidx]) begin
        dirty_q[vidx] <= 1'b1;
      end
      if (ctl_i.alloc) begin
        handed_q <= handed_q + 1'b1;
      end
      if (ctl_i.q_pop) begin
        head_q <= head_inc;
        cnt_q  <= cnt_q - 1'b1;
      end
      if (ctl_i.sweep_start) begin
        found_q <= 1'b0;
        pv_q    <= 1'b0;
      end else if (ctl_i.sweep_step) begin
        pv_q <= (32'(idx_q) < MAX_PAGES);
        if (pv_q && fault && valid_q[pidx_q]) begin
          found_q <= 1'b1;
        end
      end
      if (age_we) begin
        agew_q[age_waddr] <= 1'b1;
      end
      if (ctl_i.evict) begin
        valid_q[victim_q] <= 1'b0;
        dirty_q[victim_q] <= 1'b0;
        if (dirty_q[victim_q]) begin
          writes_q <= writes_q + 1'b1;
        end
      end
      if (ctl_i.commit) begin
        valid_q[vidx] <= 1'b1;
        reads_q       <= reads_q + 1'b1;
        if (policy_q == POLICY_FIFO) begin
          head_q <= push_head;
          cnt_q  <= push_cnt + 1'b1;
        end
      end
    end
  end

  assign sts_o.no_result  = (cmd_q == CMD_NONE);
  assign sts_o.bad        = bad;
  assign sts_o.fault      = fault;
  assign sts_o.vpn_valid  = valid_q[vidx];
  assign sts_o.free       = (32'(handed_q) < FRAMES);
  assign sts_o.policy     = policy_q;
  assign sts_o.q_empty    = (cnt_q == '0);
  assign sts_o.q_hit      = q_hit;
  assign sts_o.sweep_done = (32'(idx_q) == MAX_PAGES) && !pv_q;
  assign sts_o.found      = found_q;

  assign frame_o        = 5'(frame_q);
  assign evicted_o      = ev_q;
  assign victim_page_o  = ev_q ? 6'(victim_q) : 6'd0;
  assign write_back_o   = wb_q;
  assign not_resident_o = nr_q;
  assign disk_reads_o   = reads_q;
  assign disk_writes_o  = writes_q;

endmodule

>>> rtl/demand_page_replacement.sv
// Top level of the demand paging frame allocator with FIFO or age based replacement.
//
// Usage: raise start with cmd_i/vpn_i while busy is low; the command transaction is
// taken at that edge and busy stays high until the result has been shown. Each result
// appears for one cycle with done high; the receiver cannot stall and must take it
// then. Command 3 gives no result. Configuration writes (cfg_index_i 0 policy,
// 1 pages_in_use) are taken whenever cfg_valid_i is high, since cfg_ready_o is always
// high; write only while busy is low.
// Out-of-range items, faults on resident pages and accesses to absent pages go from
// decode straight to the result; faults that take a free frame commit first. Queue
// evictions pop entries until one holds a resident page, then read its frame, evict
// and commit. Accesses to resident pages sweep the age RAM one page per cycle; age
// evictions sweep for a victim, then, if one is found, read its frame and evict, and
// commit; a queue that runs dry falls back to that sweep. The one age RAM read per
// cycle paces the sweep. busy drops the cycle after the result, so a new item is
// taken only once the last one is through. One item at a time.
// Reset clears valid, dirty and age state, counters and the queue at once;
// no clearing pass is needed.
`timescale 1ns / 1ps
module demand_page_replacement import dpr_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  parameter int FRAMES    = FRAMES_DEF,
  parameter int AGE_BITS  = AGE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  vpn_i,
  output logic        done,
  output logic [4:0]  frame_o,
  output logic        evicted_o,
  output logic [5:0]  victim_page_o,
  output logic        write_back_o,
  output logic        not_resident_o,
  output logic [31:0] disk_reads_o,
  output logic [31:0] disk_writes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  dpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .res_valid_o (done),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  dpr_datapath #(
    .MAX_PAGES (MAX_PAGES),
    .FRAMES    (FRAMES),
    .AGE_BITS  (AGE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .vpn_i          (vpn_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .frame_o        (frame_o),
    .evicted_o      (evicted_o),
    .victim_page_o  (victim_page_o),
    .write_back_o   (write_back_o),
    .not_resident_o (not_resident_o),
    .disk_reads_o   (disk_reads_o),
    .disk_writes_o  (disk_writes_o)
  );

endmodule
